/* rtl/arn_pkg.sv */
`timescale 1ns / 1ps

package arn_pkg;

  // Fixed point and timing constants
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [10:0] MS_PER_S  = 11'd1000;
  // rate * elapsed at or above this gives a factor of 1.0 (65536 * 1000)
  localparam logic [47:0] SAT_LIMIT = 48'd65536000;

  // Register reset values
  localparam logic [15:0] ATTACK_RST = 16'd49152;  // 0.75
  localparam logic [15:0] DECAY_RST  = 16'd655;    // 0.01

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MAX_ATTACK = 2'd0,
    REG_MIN_ATTACK = 2'd1,
    REG_MAX_DECAY  = 2'd2,
    REG_MIN_DECAY  = 2'd3
  } cfg_reg_e;

  // Top level sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_KICK,
    S_LANE,
    S_NKICK,
    S_NORM,
    S_EMIT
  } top_state_e;

  // Envelope lane sequencer
  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL,
    L_DIVLD,
    L_DIV,
    L_PRT,
    L_FIN
  } lane_state_e;

  // Normalizer sequencer
  typedef enum logic [2:0] {
    N_IDLE,
    N_CLAMP,
    N_LOAD,
    N_DIV,
    N_FIN
  } norm_state_e;

  // Lane status toward the top level
  typedef struct packed {
    logic        done;
    logic [31:0] bound;
  } lane_res_t;

  // Normalizer status toward the top level
  typedef struct packed {
    logic        done;
    logic [16:0] value;
  } norm_res_t;

endpackage

/* rtl/auto_range_normalizer_core.sv */
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// input     in_valid_i / in_stall_o   has_sample_i, sample_i, timestamp_ms_i
// output    out_valid_o / out_stall_i normalized_o, range_min_o, range_max_o,
//                                     min_changed_o, max_changed_o, out_changed_o
// config    cfg_we_i                  cfg_idx_i, cfg_data_i
//
// An item after the first sample runs the two envelope lanes side by side
// through three 16-step bit-serial loops (rate * elapsed, divide by 1000,
// distance * factor), then the normalizer's 17-step divide; a flat or
// inverted range skips that divide. The first sample skips the lanes and the
// divide. A tick before the first sample is accepted and gives no result.
// Reset is asynchronous and active low; one result can wait in the output
// register while the next transaction is accepted and worked on.
module auto_range_normalizer_core import arn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               has_sample_i,
  input  logic signed [31:0] sample_i,
  input  logic        [31:0] timestamp_ms_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [16:0] normalized_o,
  output logic signed [31:0] range_min_o,
  output logic signed [31:0] range_max_o,
  output logic               min_changed_o,
  output logic               max_changed_o,
  output logic               out_changed_o
);

  top_state_e state_q, state_d;

  // Configuration
  logic [15:0] max_attack_q, min_attack_q, max_decay_q, min_decay_q;

  // Tracking state
  logic        started_q;
  logic [31:0] held_q;
  logic [31:0] min_q, max_q;
  logic [31:0] last_time_q;
  logic [16:0] last_norm_q;

  // Per-transaction working values
  logic [31:0] elapsed_q;
  logic [16:0] norm_q;
  logic        first_q, cmin_q, cmax_q;

  // Output register
  logic        out_valid_q;
  logic [16:0] out_norm_q;
  logic [31:0] out_min_q, out_max_q;
  logic        out_cmin_q, out_cmax_q, out_cnorm_q;

  logic      in_stall, in_acc;
  logic      lane_go, norm_go, out_load;
  logic      lanes_done;
  lane_res_t max_res, min_res;
  norm_res_t norm_res;

  assign in_acc     = in_valid_i & ~in_stall;
  assign lanes_done = max_res.done & min_res.done;

  // Envelope lanes: the maximum rises on attack, the minimum rises on decay
  arn_lane u_max_lane (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (lane_go),
    .value_i   (held_q),
    .bound_i   (max_q),
    .elapsed_i (elapsed_q),
    .rate_up_i (max_attack_q),
    .rate_dn_i (max_decay_q),
    .res_o     (max_res)
  );

  arn_lane u_min_lane (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (lane_go),
    .value_i   (held_q),
    .bound_i   (min_q),
    .elapsed_i (elapsed_q),
    .rate_up_i (min_decay_q),
    .rate_dn_i (min_attack_q),
    .res_o     (min_res)
  );

  arn_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_go),
    .value_i (held_q),
    .lo_i    (min_q),
    .hi_i    (max_q),
    .res_o   (norm_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (started_q) begin
            state_d = S_KICK;
          end else if (has_sample_i) begin
            state_d = S_NKICK;
          end
        end
      end
      S_KICK:  state_d = S_LANE;
      S_LANE:  if (lanes_done) state_d = S_NKICK;
      S_NKICK: state_d = S_NORM;
      S_NORM:  if (norm_res.done) state_d = S_EMIT;
      S_EMIT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall = (state_q != S_IDLE);
    lane_go  = (state_q == S_KICK);
    norm_go  = (state_q == S_NKICK);
    out_load = (state_q == S_EMIT) & (~out_valid_q | ~out_stall_i);
  end

  // Control and tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      max_attack_q <= ATTACK_RST;
      min_attack_q <= ATTACK_RST;
      max_decay_q  <= DECAY_RST;
      min_decay_q  <= DECAY_RST;
      started_q    <= 1'b0;
      held_q       <= '0;
      min_q        <= '0;
      max_q        <= 32'd65536;
      last_time_q  <= '0;
      last_norm_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // register writes
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_MAX_ATTACK: max_attack_q <= cfg_data_i;
          REG_MIN_ATTACK: min_attack_q <= cfg_data_i;
          REG_MAX_DECAY:  max_decay_q  <= cfg_data_i;
          REG_MIN_DECAY:  min_decay_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // accepted transaction
      if (in_acc) begin
        if (has_sample_i) begin
          held_q <= sample_i;
        end
        if (started_q) begin
          last_time_q <= timestamp_ms_i;
        end else if (has_sample_i) begin
          started_q   <= 1'b1;
          last_time_q <= timestamp_ms_i;
          min_q       <= sample_i;
          max_q       <= sample_i;
        end
      end

      // new envelope
      if ((state_q == S_LANE) && lanes_done) begin
        min_q <= min_res.bound;
        max_q <= max_res.bound;
      end

      if (out_load) begin
        last_norm_q <= norm_q;
      end

      // output register
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working values and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      elapsed_q <= timestamp_ms_i - last_time_q;
      first_q   <= ~started_q;
      cmin_q    <= 1'b1;
      cmax_q    <= 1'b1;
    end
    if ((state_q == S_LANE) && lanes_done) begin
      cmin_q <= (min_res.bound != min_q);
      cmax_q <= (max_res.bound != max_q);
    end
    if ((state_q == S_NORM) && norm_res.done) begin
      norm_q <= norm_res.value;
    end
    if (out_load) begin
      out_norm_q  <= norm_q;
      out_min_q   <= min_q;
      out_max_q   <= max_q;
      out_cmin_q  <= cmin_q;
      out_cmax_q  <= cmax_q;
      out_cnorm_q <= first_q | (norm_q != last_norm_q);
    end
  end

  assign in_stall_o    = in_stall;
  assign out_valid_o   = out_valid_q;
  assign normalized_o  = out_norm_q;
  assign range_min_o   = out_min_q;
  assign range_max_o   = out_max_q;
  assign min_changed_o = out_cmin_q;
  assign max_changed_o = out_cmax_q;
  assign out_changed_o = out_cnorm_q;

`ifndef SYNTHESIS
  // both lanes run in lock step
  a_lanes_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_res.done == min_res.done)
    else $error("envelope lanes out of step");

  // lane results only arrive while the sequencer waits for them
  a_lane_when: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lanes_done |-> state_q == S_LANE)
    else $error("lane result outside lane phase");

  // a transaction after the first sample always starts the lanes
  a_kick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && started_q |=> state_q == S_KICK)
    else $error("accepted transaction did not start lanes");

  // normalized value never exceeds 1.0
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normalized_o <= ONE_Q16)
    else $error("normalized value above 1.0");
`endif

endmodule

/* rtl/arn_lane.sv */
`timescale 1ns / 1ps

// One envelope edge: factor = min(rate * elapsed / 1000, 1.0) and
// bound +/- (|value - bound| * factor) >> 16, all on one shift-add /
// restoring-divide datapath, one bit per cycle.
module arn_lane import arn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] bound_i,
  input  logic        [31:0] elapsed_i,
  input  logic        [15:0] rate_up_i,
  input  logic        [15:0] rate_dn_i,
  output lane_res_t          res_o
);

  lane_state_e state_q, state_d;

  logic [3:0]  cnt_q, cnt_d;
  logic [47:0] p_q, p_d;      // product accumulator
  logic [15:0] m_q, m_d;      // multiplier bits, then quotient bits
  logic [31:0] d_q, d_d;      // distance to the value
  logic [31:0] base_q, base_d;
  logic [9:0]  rem_q, rem_d;  // remainder of the divide by 1000
  logic        up_q, up_d;
  logic        sat_q, sat_d;

  logic [32:0] diff;
  logic [32:0] neg_diff;
  logic [31:0] dist_abs;
  logic [31:0] mcand;
  logic [32:0] sum;
  logic [10:0] div_t;
  logic        div_ge;
  logic [10:0] div_r;
  logic [31:0] portion;

  // Direction and distance of the value from the bound
  assign diff     = {value_i[31], value_i} - {bound_i[31], bound_i};
  assign neg_diff = 33'd0 - diff;
  assign dist_abs = diff[32] ? neg_diff[31:0] : diff[31:0];

  // Shared shift-add step: elapsed while building the factor, distance after
  assign mcand = (state_q == L_PRT) ? d_q : elapsed_i;
  assign sum   = {1'b0, p_q[47:16]} + (m_q[0] ? {1'b0, mcand} : 33'd0);

  // Restoring divide step by 1000
  assign div_t  = {rem_q, m_q[15]};
  assign div_ge = (div_t >= MS_PER_S);
  assign div_r  = div_ge ? (div_t - MS_PER_S) : div_t;

  // Datapath
  always_comb begin
    cnt_d  = cnt_q;
    p_d    = p_q;
    m_d    = m_q;
    d_d    = d_q;
    base_d = base_q;
    rem_d  = rem_q;
    up_d   = up_q;
    sat_d  = sat_q;
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          d_d    = dist_abs;
          up_d   = ~diff[32];
          base_d = bound_i;
          m_d    = diff[32] ? rate_dn_i : rate_up_i;
          p_d    = '0;
          cnt_d  = '0;
        end
      end
      L_MUL, L_PRT: begin
        p_d   = {sum, p_q[15:1]};
        m_d   = {1'b0, m_q[15:1]};
        cnt_d = cnt_q + 4'd1;
      end
      L_DIVLD: begin
        sat_d = (p_q >= SAT_LIMIT);
        rem_d = p_q[25:16];
        m_d   = p_q[15:0];
        cnt_d = '0;
      end
      L_DIV: begin
        rem_d = div_r[9:0];
        m_d   = {m_q[14:0], div_ge};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          p_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      L_IDLE:  if (start_i) state_d = L_MUL;
      L_MUL:   if (cnt_q == 4'd15) state_d = L_DIVLD;
      L_DIVLD: state_d = L_DIV;
      L_DIV:   if (cnt_q == 4'd15) state_d = L_PRT;
      L_PRT:   if (cnt_q == 4'd15) state_d = L_FIN;
      L_FIN:   state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    portion      = sat_q ? d_q : p_q[47:16];
    res_o.done   = (state_q == L_FIN);
    res_o.bound  = up_q ? (base_q + portion) : (base_q - portion);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    p_q    <= p_d;
    m_q    <= m_d;
    d_q    <= d_d;
    base_q <= base_d;
    rem_q  <= rem_d;
    up_q   <= up_d;
    sat_q  <= sat_d;
  end

endmodule

/* rtl/arn_norm.sv */
`timescale 1ns / 1ps

// Clamp the value into [lo, hi] and divide its offset by the span,
// ((c - lo) << 16) / (hi - lo) when hi > lo, one quotient bit per cycle.
module arn_norm import arn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] lo_i,
  input  logic signed [31:0] hi_i,
  output norm_res_t          res_o
);

  norm_state_e state_q, state_d;

  logic [4:0]         cnt_q, cnt_d;
  logic signed [31:0] c_q, c_d;
  logic [31:0]        span_q, span_d;
  logic [32:0]        rem_q, rem_d;
  logic [16:0]        q_q, q_d;
  logic               gt_q, gt_d;
  logic               eq_q, eq_d;

  logic signed [31:0] c_lo;
  logic [31:0]        off;
  logic [16:0]        flat;
  logic               ge;
  logic [32:0]        r1;

  // Lower clamp and offset from the minimum
  assign c_lo = (c_q < lo_i) ? lo_i : c_q;
  assign off  = c_lo - lo_i;

  // Zero range: the value itself, held to [0, 1.0]
  always_comb begin
    if (c_lo[31]) begin
      flat = '0;
    end else if (c_lo > 32'sd65536) begin
      flat = ONE_Q16;
    end else begin
      flat = c_lo[16:0];
    end
  end

  // Restoring divide step
  assign ge = (rem_q >= {1'b0, span_q});
  assign r1 = ge ? (rem_q - {1'b0, span_q}) : rem_q;

  // Datapath
  always_comb begin
    cnt_d  = cnt_q;
    c_d    = c_q;
    span_d = span_q;
    rem_d  = rem_q;
    q_d    = q_q;
    gt_d   = gt_q;
    eq_d   = eq_q;
    case (state_q)
      N_CLAMP: begin
        c_d    = (value_i < hi_i) ? value_i : hi_i;
        span_d = hi_i - lo_i;
        gt_d   = (hi_i > lo_i);
        eq_d   = (hi_i == lo_i);
      end
      N_LOAD: begin
        rem_d = {1'b0, off};
        cnt_d = '0;
        q_d   = eq_q ? flat : 17'd0;
      end
      N_DIV: begin
        rem_d = {r1[31:0], 1'b0};
        q_d   = {q_q[15:0], ge};
        cnt_d = cnt_q + 5'd1;
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      N_IDLE:  if (start_i) state_d = N_CLAMP;
      N_CLAMP: state_d = N_LOAD;
      N_LOAD:  state_d = gt_q ? N_DIV : N_FIN;
      N_DIV:   if (cnt_q == 5'd16) state_d = N_FIN;
      N_FIN:   state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    res_o.done  = (state_q == N_FIN);
    res_o.value = q_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    c_q    <= c_d;
    span_q <= span_d;
    rem_q  <= rem_d;
    q_q    <= q_d;
    gt_q   <= gt_d;
    eq_q   <= eq_d;
  end

endmodule
